>>> rtl/pfk_pkg.sv
`default_nettype none
package pfk_pkg;

    localparam int LEN_W            = 16;
    localparam int ANG_W            = 16;
    localparam int POS_W            = 24;
    localparam int TABLE_LEN        = 24;
    localparam int ROTATE_STEPS_DEF = 16;
    localparam int GAIN_W           = 16;
    localparam int PROD_W           = LEN_W + GAIN_W;
    localparam int XY_W             = 36;
    localparam int Z_W              = 34;
    localparam int ATAN_W           = 30;
    localparam int FRAC_DROP        = 16;
    localparam int DELTA_W          = XY_W - FRAC_DROP;
    localparam int STEP_W           = $clog2(TABLE_LEN);
    localparam int SUM_W            = POS_W + 2;

    localparam logic [GAIN_W-1:0] INV_GAIN  = GAIN_W'(39797);
    localparam logic [XY_W-1:0]   ROUND_BIAS = XY_W'(32768);

    typedef struct packed {
        logic [LEN_W-1:0] link_length;
        logic [ANG_W-1:0] joint_angle;
        logic             chain_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    chain_done;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic ack;
    } t_rot_cmd;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = ATAN_W'(536870912);
            5'd1:    v = ATAN_W'(316933406);
            5'd2:    v = ATAN_W'(167458907);
            5'd3:    v = ATAN_W'(85004756);
            5'd4:    v = ATAN_W'(42667331);
            5'd5:    v = ATAN_W'(21354465);
            5'd6:    v = ATAN_W'(10679838);
            5'd7:    v = ATAN_W'(5340245);
            5'd8:    v = ATAN_W'(2670163);
            5'd9:    v = ATAN_W'(1335087);
            5'd10:   v = ATAN_W'(667544);
            5'd11:   v = ATAN_W'(333772);
            5'd12:   v = ATAN_W'(166886);
            5'd13:   v = ATAN_W'(83443);
            5'd14:   v = ATAN_W'(41722);
            5'd15:   v = ATAN_W'(20861);
            5'd16:   v = ATAN_W'(10430);
            5'd17:   v = ATAN_W'(5215);
            5'd18:   v = ATAN_W'(2608);
            5'd19:   v = ATAN_W'(1304);
            5'd20:   v = ATAN_W'(652);
            5'd21:   v = ATAN_W'(326);
            5'd22:   v = ATAN_W'(163);
            5'd23:   v = ATAN_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/planar_chain_forward_kinematics.sv
`default_nettype none
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in  (link_length, joint_angle, chain_end)
// out       output     o_out_valid / i_out_stall  o_out (pos_x, pos_y, chain_done)
//
// Each beat passes in turn through capture, the gain multiply, the rotation steps of the
// shared CORDIC unit (ROTATE_STEPS of them, capped at TABLE_LEN) and the accumulate.
// Input is stalled while a joint is in flight; the result register lets the next
// beat enter while a finished point still waits on a stalled output.
// Reset clears the running angle and position to the origin.
module planar_chain_forward_kinematics #(
    parameter int ROTATE_STEPS = pfk_pkg::ROTATE_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pfk_pkg::t_in_beat  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pfk_pkg::t_out_beat      o_out
);

    logic                                  r_busy;
    logic                                  r_out_valid;
    pfk_pkg::t_out_beat                    r_out;
    logic                                  r_last;
    logic [pfk_pkg::ANG_W-1:0]             r_angle_total;
    logic signed [pfk_pkg::POS_W-1:0]      r_x_total, r_y_total;

    logic                                  accept, take, rot_done;
    logic [pfk_pkg::ANG_W-1:0]             heading_next;
    pfk_pkg::t_rot_cmd                     cmd;
    logic signed [pfk_pkg::DELTA_W-1:0]    dx, dy;
    logic signed [pfk_pkg::SUM_W-1:0]      sum_x, sum_y;
    logic signed [pfk_pkg::POS_W-1:0]      n_x_total, n_y_total;

    localparam logic signed [pfk_pkg::SUM_W-1:0] POS_MAX =
        pfk_pkg::SUM_W'((1 << (pfk_pkg::POS_W - 1)) - 1);
    localparam logic signed [pfk_pkg::SUM_W-1:0] POS_MIN = -POS_MAX - pfk_pkg::SUM_W'(1);

    assign accept       = i_in_valid && !r_busy;
    assign take         = rot_done && (!r_out_valid || !i_out_stall);
    assign heading_next = r_angle_total + i_in.joint_angle;
    assign cmd.start    = accept;
    assign cmd.ack      = take;

    pfk_cordic #(
        .ROTATE_STEPS(ROTATE_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_len   (i_in.link_length),
        .i_angle (heading_next),
        .o_done  (rot_done),
        .o_dx    (dx),
        .o_dy    (dy)
    );

    always_comb begin
        sum_x = pfk_pkg::SUM_W'(r_x_total) + pfk_pkg::SUM_W'(dx);
        sum_y = pfk_pkg::SUM_W'(r_y_total) + pfk_pkg::SUM_W'(dy);
        priority if (sum_x > POS_MAX) begin
            n_x_total = POS_MAX[pfk_pkg::POS_W-1:0];
        end else if (sum_x < POS_MIN) begin
            n_x_total = POS_MIN[pfk_pkg::POS_W-1:0];
        end else begin
            n_x_total = sum_x[pfk_pkg::POS_W-1:0];
        end
        priority if (sum_y > POS_MAX) begin
            n_y_total = POS_MAX[pfk_pkg::POS_W-1:0];
        end else if (sum_y < POS_MIN) begin
            n_y_total = POS_MIN[pfk_pkg::POS_W-1:0];
        end else begin
            n_y_total = sum_y[pfk_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_angle_total <= '0;
            r_x_total     <= '0;
            r_y_total     <= '0;
        end else begin
            if (accept) begin
                r_busy        <= 1'b1;
                r_angle_total <= heading_next;
            end
            if (take) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_angle_total <= '0;
                    r_x_total     <= '0;
                    r_y_total     <= '0;
                end else begin
                    r_x_total <= n_x_total;
                    r_y_total <= n_y_total;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_in.chain_end;
        end
        if (take) begin
            r_out.pos_x      <= n_x_total;
            r_out.pos_y      <= n_y_total;
            r_out.chain_done <= r_last;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

>>> rtl/pfk_cordic.sv
`default_nettype none
module pfk_cordic #(
    parameter int ROTATE_STEPS = pfk_pkg::ROTATE_STEPS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pfk_pkg::t_rot_cmd                   i_cmd,
    input  wire logic [pfk_pkg::LEN_W-1:0]           i_len,
    input  wire logic [pfk_pkg::ANG_W-1:0]           i_angle,
    output logic                                     o_done,
    output logic signed [pfk_pkg::DELTA_W-1:0]       o_dx,
    output logic signed [pfk_pkg::DELTA_W-1:0]       o_dy
);

    localparam int NUM_ITER = (ROTATE_STEPS < pfk_pkg::TABLE_LEN) ?
                              ROTATE_STEPS : pfk_pkg::TABLE_LEN;
    localparam logic [pfk_pkg::STEP_W-1:0] LAST_STEP = pfk_pkg::STEP_W'(NUM_ITER - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ROT  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [pfk_pkg::LEN_W-1:0]        r_len;
    logic                             r_neg;
    logic signed [pfk_pkg::XY_W-1:0]  r_x, n_x;
    logic signed [pfk_pkg::XY_W-1:0]  r_y, n_y;
    logic signed [pfk_pkg::Z_W-1:0]   r_z, n_z;
    logic [pfk_pkg::STEP_W-1:0]       r_step;

    logic [pfk_pkg::ANG_W-1:0]        fold_angle;
    logic                             fold_neg;
    logic [pfk_pkg::PROD_W-1:0]       prod;
    logic signed [pfk_pkg::XY_W-1:0]  xs, ys;
    logic signed [pfk_pkg::Z_W-1:0]   atan_z;
    logic signed [pfk_pkg::XY_W-1:0]  x_round, y_round;

    assign fold_neg   = i_angle[15] ^ i_angle[14];
    assign fold_angle = {i_angle[15] ^ fold_neg, i_angle[14:0]};
    assign prod       = pfk_pkg::PROD_W'(r_len) * pfk_pkg::PROD_W'(pfk_pkg::INV_GAIN);
    assign xs         = r_x >>> r_step;
    assign ys         = r_y >>> r_step;
    assign atan_z     = pfk_pkg::Z_W'(pfk_pkg::atan_entry(r_step));

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_x     = r_neg ? -pfk_pkg::XY_W'(prod) : pfk_pkg::XY_W'(prod);
                n_y     = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (!r_z[pfk_pkg::Z_W-1]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_z;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_z;
                end
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_cmd.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ROT) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        if (r_state == ST_IDLE && i_cmd.start) begin
            r_len <= i_len;
            r_neg <= fold_neg;
            r_z   <= {{(pfk_pkg::Z_W - pfk_pkg::ANG_W - 16){fold_angle[15]}},
                      fold_angle, 16'h0000};
        end else begin
            r_z <= n_z;
        end
    end

    assign x_round = r_x + pfk_pkg::ROUND_BIAS;
    assign y_round = r_y + pfk_pkg::ROUND_BIAS;
    assign o_dx    = x_round[pfk_pkg::XY_W-1:pfk_pkg::FRAC_DROP];
    assign o_dy    = y_round[pfk_pkg::XY_W-1:pfk_pkg::FRAC_DROP];
    assign o_done  = (r_state == ST_DONE);

endmodule
`default_nettype wire

>>> sim/fk_check_pkg.sv
`timescale 1ns / 1ps
package fk_check_pkg;

    localparam int     TURN_STEPS = pfk_pkg::ROTATE_STEPS_DEF;
    localparam int     ATAN_LEN   = 24;
    localparam longint LINK_GAIN  = 39797;
    localparam longint POS_HI     = 8388607;
    localparam longint POS_LO     = -8388608;
    localparam longint ATAN_Q32 [ATAN_LEN] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    class chain_scoreboard;
        logic [pfk_pkg::ANG_W-1:0] heading;
        longint                    tip_x;
        longint                    tip_y;
        pfk_pkg::t_out_beat        points_due[$];
        int                        mismatches;
        int                        points_seen;

        function new();
            heading     = '0;
            tip_x       = 0;
            tip_y       = 0;
            mismatches  = 0;
            points_seen = 0;
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_HI) return POS_HI;
            if (v < POS_LO) return POS_LO;
            return v;
        endfunction

        function void rotate_link(input logic [pfk_pkg::LEN_W-1:0] len,
                                  input logic [pfk_pkg::ANG_W-1:0] ang,
                                  output longint dx, output longint dy);
            longint                    x;
            longint                    y;
            longint                    z;
            longint                    xs;
            longint                    ys;
            logic [pfk_pkg::ANG_W-1:0] a;
            x = LINK_GAIN * len;
            y = 0;
            a = ang;
            // Fold the left half-plane onto the right one so the residual fits the CORDIC range.
            if (a[pfk_pkg::ANG_W-1] != a[pfk_pkg::ANG_W-2]) begin
                x = -x;
                a = a - 16'h8000;
            end
            z = longint'($signed(a)) * 65536;
            for (int i = 0; i < TURN_STEPS && i < ATAN_LEN; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_Q32[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_Q32[i];
                end
            end
            dx = (x + 32768) >>> 16;
            dy = (y + 32768) >>> 16;
        endfunction

        function void note_joint(pfk_pkg::t_in_beat b);
            longint             dx;
            longint             dy;
            pfk_pkg::t_out_beat p;
            heading = heading + b.joint_angle;
            rotate_link(b.link_length, heading, dx, dy);
            tip_x = clamp_pos(tip_x + dx);
            tip_y = clamp_pos(tip_y + dy);
            p.pos_x      = tip_x[pfk_pkg::POS_W-1:0];
            p.pos_y      = tip_y[pfk_pkg::POS_W-1:0];
            p.chain_done = b.chain_end;
            points_due   = {points_due, p};
            if (b.chain_end) begin
                heading = '0;
                tip_x   = 0;
                tip_y   = 0;
            end
        endfunction

        function void check_point(pfk_pkg::t_out_beat got);
            pfk_pkg::t_out_beat want;
            points_seen++;
            if (points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("point %0d arrived with none due: x=%0d y=%0d done=%0b",
                             points_seen, got.pos_x, got.pos_y, got.chain_done);
                end
                return;
            end
            want = points_due.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
                    || got.chain_done !== want.chain_done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("point %0d: expected x=%0d y=%0d done=%0b, got x=%0d y=%0d done=%0b",
                             points_seen, want.pos_x, want.pos_y, want.chain_done,
                             got.pos_x, got.pos_y, got.chain_done);
                end
            end
        endfunction
    endclass

endpackage

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 29;
    localparam int TOTAL_JOINTS  = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 60;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pfk_pkg::t_in_beat  i_in        = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    pfk_pkg::t_out_beat o_out;

    fk_check_pkg::chain_scoreboard sb;
    int cycle_count = 0;
    int joints_sent = 0;
    int chains_sent = 0;
    int chain_no    = 0;
    int hold_req    = 0;
    int hold_left   = 0;
    bit calm        = 1'b0;

    planar_chain_forward_kinematics DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points still due", cycle_count,
                     sb.points_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_point(o_out);
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_joint(input logic [pfk_pkg::LEN_W-1:0] len,
                              input logic [pfk_pkg::ANG_W-1:0] ang,
                              input logic last);
        pfk_pkg::t_in_beat b;
        b.link_length = len;
        b.joint_angle = ang;
        b.chain_end   = last;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_joint(b);
        joints_sent++;
        if (last) chains_sent++;
    endtask

    task automatic wait_for_points();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.points_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [pfk_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return pfk_pkg::LEN_W'($urandom);
    endfunction

    function automatic logic [pfk_pkg::ANG_W-1:0] pick_angle();
        logic [pfk_pkg::ANG_W-1:0] edges [8] = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
                                                 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        if ($urandom_range(99) < 15) return edges[$urandom_range(7)];
        return pfk_pkg::ANG_W'($urandom);
    endfunction

    task automatic send_random_chain(input int n);
        for (int k = 0; k < n; k++) begin
            send_joint(pick_length(), pick_angle(), k == n - 1);
        end
    endtask

    // A nearly straight run of long links drives the tip into the clamp, and the
    // closing links turn around and bring it back in range.
    task automatic send_long_chain();
        int n;
        n = $urandom_range(140, 180);
        send_joint(16'hFF00 | pfk_pkg::LEN_W'($urandom_range(255)),
                   pfk_pkg::ANG_W'($urandom_range(3)) << 14, 1'b0);
        for (int k = 1; k < n; k++) begin
            send_joint(16'hFF00 | pfk_pkg::LEN_W'($urandom_range(255)),
                       pfk_pkg::ANG_W'($urandom_range(6)) - 16'd3, 1'b0);
        end
        send_joint(16'hFFFF, 16'h8000, 1'b0);
        for (int k = 0; k < 24; k++) begin
            send_joint(16'hFFFF, 16'h0000, k == 23);
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_joint(16'h0000, 16'h0000, 1'b1);
        send_joint(16'hFFFF, 16'h0000, 1'b1);
        send_joint(16'hFFFF, 16'h3FFF, 1'b1);
        send_joint(16'hFFFF, 16'h4000, 1'b1);
        send_joint(16'hFFFF, 16'h7FFF, 1'b1);
        send_joint(16'hFFFF, 16'h8000, 1'b1);
        send_joint(16'hFFFF, 16'hBFFF, 1'b1);
        send_joint(16'hFFFF, 16'hC000, 1'b1);
        send_joint(16'hFFFF, 16'hFFFF, 1'b1);
        send_joint(16'h0001, 16'h2000, 1'b1);
        send_joint(16'h1000, 16'h2000, 1'b0);
        send_joint(16'h0000, 16'h1234, 1'b0);
        send_joint(16'h2000, 16'hE000, 1'b0);
        send_joint(16'hFFFF, 16'h8000, 1'b0);
        send_joint(16'h0800, 16'hFFFF, 1'b1);

        while (joints_sent < TOTAL_JOINTS) begin
            chain_no++;
            calm = (chain_no >= 150 && chain_no < 200);
            if (chain_no == 20) hold_req = HOLD_CYCLES;
            if (chain_no == 100) wait_for_points();
            if (chain_no % 150 == 75) begin
                send_long_chain();
            end else begin
                send_random_chain($urandom_range(1, 8));
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.points_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.points_due.size() != 0) begin
            $display("%0d points never arrived", sb.points_due.size());
        end
        $display("%0d joints in %0d chains, %0d points checked, %0d mismatches, %0d cycles",
                 joints_sent, chains_sent, sb.points_seen, sb.mismatches, cycle_count);
        $display("Covered angle quadrant edges, zero and full links, clamped chains, %s",
                 "a long output hold-off and a full drain.");
        if (sb.mismatches == 0 && sb.points_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
